[hdl/wva_pkg.sv]
// wind vector averager: shared types, constants and the arctangent table
// no dependencies; compiled first
`default_nettype none

package wva_pkg;

    localparam int CORD_W  = 40;   // cordic x/y datapath
    localparam int ZW      = 32;   // cordic angle, degrees in q.16
    localparam int DIV_W   = 24;   // divider dividend/quotient
    localparam int DEN_W   = 9;    // divider divisor
    localparam int STEP_W  = 5;    // cordic step index (table has 23 rows)
    localparam int MUL_A_W = 19;   // multiplier operand
    localparam int MUL_K_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_K_W;
    localparam int ACC_W   = 55;   // gain-corrected magnitude accumulator
    localparam int SUM_W   = 24;

    localparam logic [MUL_K_W-1:0] INV_GAIN = 16'd39797;

    // calibration divides by reciprocal multiply, exact for numerators below 2^20
    localparam int               REC_W     = 24;
    localparam int               CAL_SHIFT = 25;
    localparam logic [REC_W-1:0] REC_DIV3  = 24'd11184811;  // ceil(2^25 / 3)
    localparam logic [REC_W-1:0] REC_DIV7  = 24'd4793491;   // ceil(2^25 / 7)
    localparam logic [REC_W-1:0] REC_DIV27 = 24'd1242757;   // ceil(2^25 / 27)

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_CARRY_MEAN      = 2'd1;
    localparam logic [1:0] CFG_SPIKE_THRESHOLD = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_GAIN,
        ST_ROT,
        ST_ACC,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_VINIT,
        ST_VEC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y
    } div_sel_t;

    typedef struct packed {
        logic              pulse;
        logic              tick_load;
        logic              div_start;
        div_sel_t          div_sel;
        logic              sp_load;
        logic              gain_load;
        logic              rot_step;
        logic              acc;
        logic              mx_load;
        logic              my_load;
        logic              vec_init;
        logic              vec_step;
        logic              mul_lo;
        logic              mul_hi;
        logic              fin;
        logic [STEP_W-1:0] step;
    } wva_cmd_t;

    typedef struct packed {
        logic div_done;
        logic fire;
        logic mean_zero;
        logic out_free;
    } wva_stat_t;

    // round(atan(2^-i) in degrees * 65536)
    function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'd2949120;
            5'd1:    v = 32'd1740967;
            5'd2:    v = 32'd919879;
            5'd3:    v = 32'd466945;
            5'd4:    v = 32'd234379;
            5'd5:    v = 32'd117306;
            5'd6:    v = 32'd58666;
            5'd7:    v = 32'd29335;
            5'd8:    v = 32'd14668;
            5'd9:    v = 32'd7334;
            5'd10:   v = 32'd3667;
            5'd11:   v = 32'd1833;
            5'd12:   v = 32'd917;
            5'd13:   v = 32'd458;
            5'd14:   v = 32'd229;
            5'd15:   v = 32'd115;
            5'd16:   v = 32'd57;
            5'd17:   v = 32'd29;
            5'd18:   v = 32'd14;
            5'd19:   v = 32'd7;
            5'd20:   v = 32'd4;
            5'd21:   v = 32'd2;
            5'd22:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/wva_in_if.sv]
// input channel: pulse and tick words
// no dependencies
`default_nettype none

interface wva_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [15:0] capture_time;
    logic [8:0] vane_angle;

    modport source (output valid, output req_type, output capture_time, output vane_angle,
                    input ready);
    modport sink   (input valid, input req_type, input capture_time, input vane_angle,
                    output ready);
endinterface

`default_nettype wire

[hdl/wva_out_if.sv]
// output channel: window result words
// no dependencies
`default_nettype none

interface wva_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mean_speed;
    logic [8:0]  mean_bearing;
    logic [15:0] min_speed;
    logic [15:0] max_speed;

    modport source (output valid, output mean_speed, output mean_bearing,
                    output min_speed, output max_speed, input ready);
    modport sink   (input valid, input mean_speed, input mean_bearing,
                    input min_speed, input max_speed, output ready);
endinterface

`default_nettype wire

[hdl/wva_cfg_if.sv]
// configuration write channel
// no dependencies
`default_nettype none

interface wva_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

[hdl/wva_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on wva_pkg
`default_nettype none

module wva_div
    import wva_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [DIV_W-1:0]      quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        trial     = {rem_reg, q_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            den_next  = den;
            q_next    = num;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

[hdl/wva_ctrl.sv]
// sequencing state machine for pulse and tick handling
// depends on wva_pkg
`default_nettype none

module wva_ctrl
    import wva_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_req_type,
    output logic           in_ready,
    input  wire wva_stat_t stat,
    output wva_cmd_t       cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid && in_req_type) state_next = ST_CAL;
            ST_CAL:      state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_ROT;
            ST_ROT:      if (last_step) state_next = ST_ACC;
            ST_ACC:      state_next = stat.fire ? ST_DX_GO : ST_IDLE;
            ST_DX_GO:    state_next = ST_DX_WAIT;
            ST_DX_WAIT:  if (stat.div_done) state_next = ST_DY_GO;
            ST_DY_GO:    state_next = ST_DY_WAIT;
            ST_DY_WAIT:  if (stat.div_done) state_next = ST_VINIT;
            ST_VINIT:    state_next = stat.mean_zero ? ST_FIN : ST_VEC;
            ST_VEC:      if (last_step) state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_FIN;
            ST_FIN:      if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.step  = step_reg;
        in_ready  = 1'b0;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.pulse     = in_valid && !in_req_type;
                cmd.tick_load = in_valid && in_req_type;
            end
            ST_CAL:      cmd.sp_load = 1'b1;
            ST_GAIN:
            begin
                cmd.gain_load = 1'b1;
                step_next     = '0;
            end
            ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                step_next    = step_reg + 1'b1;
            end
            ST_ACC:      cmd.acc = 1'b1;
            ST_DX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_X;
            end
            ST_DX_WAIT:  cmd.mx_load = stat.div_done;
            ST_DY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_Y;
            end
            ST_DY_WAIT:  cmd.my_load = stat.div_done;
            ST_VINIT:
            begin
                cmd.vec_init = 1'b1;
                step_next    = '0;
            end
            ST_VEC:
            begin
                cmd.vec_step = 1'b1;
                step_next    = step_reg + 1'b1;
            end
            ST_MUL_LO:   cmd.mul_lo = 1'b1;
            ST_MUL_HI:   cmd.mul_hi = 1'b1;
            ST_FIN:      cmd.fin = stat.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

[hdl/wva_datapath.sv]
// accumulator, cordic, multiplier and result registers of the averager
// depends on wva_pkg and wva_div
`default_nettype none

module wva_datapath
    import wva_pkg::*;
#(
    parameter int COUNT_BITS = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire wva_cmd_t    cmd,
    output wva_stat_t        stat,
    input  wire logic [15:0] in_capture_time,
    input  wire logic [8:0]  in_vane_angle,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [15:0]      out_mean_speed,
    output logic [8:0]       out_mean_bearing,
    output logic [15:0]      out_min_speed,
    output logic [15:0]      out_max_speed
);

    localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;
    localparam int                    CAL_P_W  = DIV_W + REC_W;

    // configuration
    logic [7:0]  wlen_reg;
    logic        carry_reg;
    logic [15:0] thr_reg;

    // architectural state
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [15:0]             last_cap_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [7:0]              tick_reg;
    logic [15:0]             min_reg, max_reg;
    logic                    out_valid_reg;

    // working registers
    logic [DIV_W-1:0]         cal_num_reg;
    logic [REC_W-1:0]         cal_rec_reg;
    logic signed [9:0]        bdeg_reg;
    logic                     neg_reg;
    logic [15:0]              sp_reg;
    logic signed [CORD_W-1:0] x_reg, y_reg;
    logic signed [ZW-1:0]     z_reg;
    logic [8:0]               n_reg;
    logic signed [SUM_W-1:0]  mx_reg, my_reg;
    logic                     zero_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [15:0]              mean_reg, minw_reg, maxw_reg;
    logic [8:0]               brg_reg;

    // pulse gate
    logic [15:0] gap;
    assign gap = in_capture_time - last_cap_reg;

    // calibration operands from the pulse count
    logic [DIV_W-1:0] c_ext, cal_num;
    logic [REC_W-1:0] cal_rec;
    always_comb
    begin
        c_ext = DIV_W'(cnt_reg);
        if (c_ext < DIV_W'(140))
        begin
            cal_num = (c_ext << 7) + (c_ext << 5);
            cal_rec = REC_DIV27;
        end
        else if (c_ext < DIV_W'(170))
        begin
            cal_num = c_ext << 4;
            cal_rec = REC_DIV3;
        end
        else if (c_ext < DIV_W'(210))
        begin
            cal_num = c_ext << 5;
            cal_rec = REC_DIV7;
        end
        else
        begin
            cal_num = c_ext << 3;
            cal_rec = REC_DIV3;
        end
    end

    // calibrated speed: numerator times reciprocal, then drop the scale
    logic [CAL_P_W-1:0] cal_prod, cal_quo;
    logic [15:0]        sp_sat;
    assign cal_prod = CAL_P_W'(cal_num_reg) * CAL_P_W'(cal_rec_reg);
    assign cal_quo  = cal_prod >> CAL_SHIFT;
    assign sp_sat   = (cal_quo > CAL_P_W'(16'hFFFF)) ? 16'hFFFF : cal_quo[15:0];

    // vane angle folded into [-90, 90] with a sign flag
    logic [8:0]        a_red;
    logic signed [9:0] b_raw, b_fold;
    logic              b_neg;
    always_comb
    begin
        a_red  = (in_vane_angle >= 9'd360) ? in_vane_angle - 9'd360 : in_vane_angle;
        b_raw  = 10'sd90 - $signed({1'b0, a_red});
        b_neg  = (b_raw < -10'sd90);
        b_fold = b_neg ? b_raw + 10'sd180 : b_raw;
    end

    // divider for the window means
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [SUM_W-1:0] abs_x, abs_y;
    assign abs_x = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign abs_y = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign div_den = n_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_Y:   div_num = abs_y + DIV_W'(n_reg >> 1);
            default: div_num = abs_x + DIV_W'(n_reg >> 1);
        endcase
    end

    wva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    logic signed [SUM_W-1:0] q_pos, q_neg;
    assign q_pos  = $signed(div_quo);
    assign q_neg  = -$signed(div_quo);

    // shared gain multiplier
    logic [CORD_W-1:0]  x_clamp;
    logic [MUL_A_W-1:0] mul_a;
    logic [PROD_W-1:0]  prod;
    assign x_clamp = x_reg[CORD_W-1] ? '0 : x_reg;
    always_comb
    begin
        if (cmd.mul_lo)
            mul_a = x_clamp[MUL_A_W-1:0];
        else if (cmd.mul_hi)
            mul_a = x_clamp[2*MUL_A_W-1:MUL_A_W];
        else
            mul_a = MUL_A_W'(sp_reg);
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(INV_GAIN);

    // one cordic micro-rotation
    logic signed [CORD_W-1:0] xs, ys, x_step, y_step;
    logic signed [ZW-1:0]     at, z_step;
    logic                     ccw;
    always_comb
    begin
        xs  = x_reg >>> cmd.step;
        ys  = y_reg >>> cmd.step;
        at  = $signed(atan_lut(cmd.step));
        ccw = cmd.rot_step ? !z_reg[ZW-1] : !(!y_reg[CORD_W-1] && (y_reg != '0));
        if (ccw)
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + at;
        end
    end

    // component rounding and saturating accumulation
    logic signed [CORD_W-1:0] cx_r, cy_r, cx, cy;
    logic signed [SUM_W+1:0]  sx, sy;
    logic signed [SUM_W-1:0]  sx_sat, sy_sat;
    logic [8:0]               n_now;
    always_comb
    begin
        cx_r = (x_reg + CORD_W'(128)) >>> 8;
        cy_r = (y_reg + CORD_W'(128)) >>> 8;
        cx   = neg_reg ? -cx_r : cx_r;
        cy   = neg_reg ? -cy_r : cy_r;
        sx   = (SUM_W+2)'(sum_x_reg) + cx[SUM_W+1:0];
        sy   = (SUM_W+2)'(sum_y_reg) + cy[SUM_W+1:0];
        if (sx > (SUM_W+2)'(8388607))
            sx_sat = 24'sh7FFFFF;
        else if (sx < -(SUM_W+2)'(8388608))
            sx_sat = -24'sh800000;
        else
            sx_sat = sx[SUM_W-1:0];
        if (sy > (SUM_W+2)'(8388607))
            sy_sat = 24'sh7FFFFF;
        else if (sy < -(SUM_W+2)'(8388608))
            sy_sat = -24'sh800000;
        else
            sy_sat = sy[SUM_W-1:0];
        n_now = {1'b0, tick_reg} + 9'd1;
    end

    // vectoring seed
    logic signed [CORD_W-1:0] xv, yv;
    assign xv = {{(CORD_W-SUM_W-12){mx_reg[SUM_W-1]}}, mx_reg, 12'd0};
    assign yv = {{(CORD_W-SUM_W-12){my_reg[SUM_W-1]}}, my_reg, 12'd0};

    // final magnitude and bearing
    logic [ACC_W-1:0]     mag_w;
    logic [15:0]          mag;
    logic signed [ZW-1:0] bb, bb_w, bb_r;
    logic [8:0]           brg;
    always_comb
    begin
        mag_w = acc_reg >> 28;
        mag   = (mag_w > ACC_W'(16'hFFFF)) ? 16'hFFFF : mag_w[15:0];
        bb    = 32'sd5898240 - z_reg;
        bb_w  = bb[ZW-1] ? bb + 32'sd23592960 : bb;
        bb_r  = (bb_w + 32'sd32768) >>> 16;
        brg   = (bb_r[8:0] >= 9'd360) ? 9'd0 : bb_r[8:0];
        if (zero_reg)
        begin
            mag = 16'd0;
            brg = 9'd0;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.fire      = carry_reg ? (n_now > {1'b0, wlen_reg}) : (n_now >= {1'b0, wlen_reg});
    assign stat.mean_zero = (mx_reg == '0) && (my_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= 8'd10;
            carry_reg     <= 1'b0;
            thr_reg       <= 16'd10;
            cnt_reg       <= '0;
            last_cap_reg  <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            tick_reg      <= '0;
            min_reg       <= 16'hFFFF;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:   wlen_reg  <= cfg_data[7:0];
                    CFG_CARRY_MEAN:      carry_reg <= cfg_data[0];
                    CFG_SPIKE_THRESHOLD: thr_reg   <= cfg_data;
                    default:             wlen_reg  <= wlen_reg;
                endcase
            end
            if (cmd.pulse && (gap > thr_reg))
            begin
                if (cnt_reg != CNT_FULL)
                    cnt_reg <= cnt_reg + 1'b1;
                last_cap_reg <= in_capture_time;
            end
            if (cmd.tick_load)
                cnt_reg <= '0;
            if (cmd.acc)
            begin
                sum_x_reg <= sx_sat;
                sum_y_reg <= sy_sat;
                if (sp_reg < min_reg)
                    min_reg <= sp_reg;
                if (sp_reg > max_reg)
                    max_reg <= sp_reg;
                if (!stat.fire)
                    tick_reg <= n_now[7:0];
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
                if (carry_reg)
                begin
                    sum_x_reg <= mx_reg;
                    sum_y_reg <= my_reg;
                    tick_reg  <= 8'd1;
                    min_reg   <= mag;
                    max_reg   <= mag;
                end
                else
                begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    tick_reg  <= '0;
                    min_reg   <= 16'hFFFF;
                    max_reg   <= '0;
                end
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.tick_load)
        begin
            cal_num_reg <= cal_num;
            cal_rec_reg <= cal_rec;
            bdeg_reg    <= b_fold;
            neg_reg     <= b_neg;
        end
        if (cmd.sp_load)
            sp_reg <= sp_sat;
        if (cmd.gain_load)
        begin
            x_reg <= CORD_W'(prod[PROD_W-1:8]);
            y_reg <= '0;
            z_reg <= {{(ZW-26){bdeg_reg[9]}}, bdeg_reg, 16'd0};
        end
        if (cmd.rot_step || cmd.vec_step)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
        if (cmd.acc)
            n_reg <= n_now;
        if (cmd.mx_load)
            mx_reg <= sum_x_reg[SUM_W-1] ? q_neg : q_pos;
        if (cmd.my_load)
            my_reg <= sum_y_reg[SUM_W-1] ? q_neg : q_pos;
        if (cmd.vec_init)
        begin
            zero_reg <= stat.mean_zero;
            if (mx_reg[SUM_W-1])
            begin
                x_reg <= -xv;
                y_reg <= -yv;
                z_reg <= 32'sd11796480;
            end
            else
            begin
                x_reg <= xv;
                y_reg <= yv;
                z_reg <= '0;
            end
        end
        if (cmd.mul_lo)
            acc_reg <= ACC_W'(prod);
        if (cmd.mul_hi)
            acc_reg <= acc_reg + (ACC_W'(prod) << MUL_A_W) + (ACC_W'(1) << 27);
        if (cmd.fin)
        begin
            mean_reg <= mag;
            brg_reg  <= brg;
            minw_reg <= min_reg;
            maxw_reg <= max_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_mean_speed   = mean_reg;
    assign out_mean_bearing = brg_reg;
    assign out_min_speed    = minw_reg;
    assign out_max_speed    = maxw_reg;

endmodule

`default_nettype wire

[hdl/wind_vector_averager_core.sv]
// a pulse word is taken in idle; a tick word runs calibration, gain load, cordic rotation and
// accumulation, and when it closes the window the mean divisions, vectoring and multiply
// flow: one word at a time; the two 24-step mean divisions and the
// iterative cordic set the tick time, a stalled result word adds its stall
// reset: rst_n asynchronous, active low; counts, sums, extrema, out valid and config to defaults
`default_nettype none

module wind_vector_averager_core
    import wva_pkg::*;
#(
    parameter int COUNT_BITS   = 12,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    wva_in_if.sink    in_ch,
    wva_out_if.source out_ch,
    wva_cfg_if.sink   cfg_ch
);

    wva_cmd_t  cmd;
    wva_stat_t stat;

    // configuration writes are taken in any cycle
    assign cfg_ch.ready = 1'b1;

    // controller: takes words in idle, then steps the tick sequence
    wva_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_req_type (in_ch.req_type),
        .in_ready    (in_ch.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // datapath: pulse gate, calibration multiply, cordic, mean divider, sums and result register
    wva_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_capture_time  (in_ch.capture_time),
        .in_vane_angle    (in_ch.vane_angle),
        .cfg_we           (cfg_ch.valid),
        .cfg_index        (cfg_ch.reg_index),
        .cfg_data         (cfg_ch.data),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_mean_speed   (out_ch.mean_speed),
        .out_mean_bearing (out_ch.mean_bearing),
        .out_min_speed    (out_ch.min_speed),
        .out_max_speed    (out_ch.max_speed)
    );

endmodule

`default_nettype wire

[hdl/wva_checker.sv]
// port-level checks for the averager, bound to the top level
// depends on wind_vector_averager_core
`default_nettype none

module wva_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] mean_speed,
    input wire logic [8:0]  mean_bearing,
    input wire logic [15:0] min_speed,
    input wire logic [15:0] max_speed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mean_speed) && $stable(mean_bearing))
        else $error("result word changed while stalled");

    a_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_bearing < 9'd360)
        else $error("bearing out of range");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_speed <= max_speed)
        else $error("window minimum above maximum");

endmodule

bind wind_vector_averager_core wva_checker u_wva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .mean_speed   (out_ch.mean_speed),
    .mean_bearing (out_ch.mean_bearing),
    .min_speed    (out_ch.min_speed),
    .max_speed    (out_ch.max_speed)
);

`default_nettype wire
